>>> hdl/conv3x3_rgb_filter_top_macros.svh
// Assertion macros shared by the RTL of the 3x3 RGB filter.
`ifndef CONV3X3_RGB_FILTER_TOP_MACROS_SVH
`define CONV3X3_RGB_FILTER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define C3_ASSERT_IMPLY(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define C3_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define C3_ASSERT_IMPLY(name, clk_i, rstn_i, ante, cons)
`define C3_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons)
`endif
`endif

>>> hdl/c3rgb_pkg.sv
// Types, constants and arithmetic helpers of the 3x3 RGB filter.
package c3rgb_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int COEF_FRAC_BITS = 8;

	localparam int PIX_W   = 8;
	localparam int RGB_W   = 24;
	localparam int RGBA_W  = 32;
	localparam int COEF_W  = 16;
	localparam int KROW_W  = 48;
	localparam int DIM_W   = 12;
	localparam int COL_W   = 11;
	localparam int ROW_W   = 12;
	localparam int CFG_W   = 64;
	localparam int PADDR_W = 6;
	localparam int OUT_W   = 56;

	// product of a 16-bit coefficient and an 8-bit pixel, and its sums
	localparam int PROD_W = 25;
	localparam int RSUM_W = 27;
	localparam int TSUM_W = 29;

	localparam logic [2:0] REG_KERNEL_TOP    = 3'd0;
	localparam logic [2:0] REG_KERNEL_MIDDLE = 3'd1;
	localparam logic [2:0] REG_KERNEL_BOTTOM = 3'd2;
	localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd3;
	localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd4;

	localparam logic [KROW_W-1:0] KERNEL_TOP_RESET    = 48'h0;
	localparam logic [KROW_W-1:0] KERNEL_MIDDLE_RESET = 48'h0000_0100_0000;
	localparam logic [KROW_W-1:0] KERNEL_BOTTOM_RESET = 48'h0;
	localparam logic [DIM_W-1:0]  WIDTH_RESET         = 12'd640;
	localparam logic [DIM_W-1:0]  HEIGHT_RESET        = 12'd480;

	typedef logic [RGB_W-1:0] rgb_t;

	typedef struct packed {
		logic              last;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [PIX_W-1:0]  alpha;
	} meta_t;

	function automatic logic signed [PROD_W-1:0] mul_coef(
		input logic [COEF_W-1:0] k,
		input logic [PIX_W-1:0]  p
	);
		logic signed [PROD_W-1:0] ke;
		logic signed [PROD_W-1:0] pe;
		ke = {{(PROD_W-COEF_W){k[COEF_W-1]}}, k};
		pe = {{(PROD_W-PIX_W){1'b0}}, p};
		return ke * pe;
	endfunction

	// add one half, floor, clamp to 0..255
	function automatic logic [PIX_W-1:0] round_clamp(input logic signed [TSUM_W-1:0] s);
		logic signed [TSUM_W-1:0] t;
		logic [PIX_W-1:0] r;
		t = s + TSUM_W'(1 << (COEF_FRAC_BITS - 1));
		if (t[TSUM_W-1]) begin
			r = '0;
		end else if (|t[TSUM_W-2:COEF_FRAC_BITS+PIX_W]) begin
			r = '1;
		end else begin
			r = t[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
		end
		return r;
	endfunction

endpackage

>>> hdl/conv3x3_rgb_filter_top.sv
// 3x3 RGB convolution filter over a raster pixel stream, with APB register port.
`include "conv3x3_rgb_filter_top_macros.svh"
// Takes one RGBA pixel per clock in raster order while the output is not stalled,
// and emits one filtered pixel for each interior position, at the arrival of the
// pixel to its lower right; border pixels produce no output. Sustained rate is one
// pixel per cycle, set by the single read and write port of each line store, which
// is read and written once per pixel. The accept edge loads the line store read;
// then come the window shift, products, row sums and the final sum with rounding
// and clamping into the output register. A stalled output holds the whole pipeline.
// tlast marks the last interior pixel of an image. Write the kernel and image size
// only while the stream is idle.
module conv3x3_rgb_filter_top #(
	parameter int MAX_WIDTH = c3rgb_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [c3rgb_pkg::PADDR_W-1:0]   paddr,
	input  logic [c3rgb_pkg::CFG_W-1:0]     pwdata,
	output logic [c3rgb_pkg::CFG_W-1:0]     prdata,
	output logic                            pready,
	// pixel input
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// red_in[7:0], green_in[15:8], blue_in[23:16], alpha_in[31:24]
	input  logic [c3rgb_pkg::RGBA_W-1:0]    s_axis_tdata,
	// filtered output
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// out_col[10:0], out_row[22:11], red_out[30:23], green_out[38:31],
	// blue_out[46:39], alpha_out[54:47], zero[55]
	output logic [c3rgb_pkg::OUT_W-1:0]     m_axis_tdata,
	output logic                            m_axis_tlast   // frame_done
);

	localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int CMPW = (WW > c3rgb_pkg::DIM_W) ? WW : c3rgb_pkg::DIM_W;

	// configuration
	logic [c3rgb_pkg::KROW_W-1:0] ktop_q, kmid_q, kbot_q;
	logic [c3rgb_pkg::DIM_W-1:0]  width_q, height_q;
	logic [c3rgb_pkg::KROW_W-1:0] krow [3];
	logic                         cfg_wr;

	// position tracking
	logic [AW-1:0]               col_q;
	logic [c3rgb_pkg::ROW_W-1:0] row_q;
	logic [CMPW-1:0]             w_eff;
	logic [c3rgb_pkg::ROW_W-1:0] h_eff;
	logic                        wrap0;
	logic [c3rgb_pkg::ROW_W-1:0] rtmp0, r0, r0_inc;
	logic [AW-1:0]               c0;
	logic [CMPW-1:0]             c0_next;
	logic                        emit0, last0;

	logic adv, accept;

	// line stores
	logic [c3rgb_pkg::RGBA_W-1:0] prev_mem [MAX_WIDTH];
	logic [c3rgb_pkg::RGB_W-1:0]  old_mem  [MAX_WIDTH];

	// stage 1: line store data
	logic                          v_s1, emit_s1, last_s1, fwd_s1;
	logic [AW-1:0]                 c_s1;
	logic [c3rgb_pkg::COL_W-1:0]   col_s1;
	logic [c3rgb_pkg::ROW_W-1:0]   row_s1;
	c3rgb_pkg::rgb_t               rgb_s1;
	logic [c3rgb_pkg::PIX_W-1:0]   alpha_s1;
	logic [c3rgb_pkg::RGBA_W-1:0]  prev_ram_s1, fwd_prev_s1, prev_val;
	logic [c3rgb_pkg::RGB_W-1:0]   old_ram_s1, fwd_old_s1, old_val;

	// window
	c3rgb_pkg::rgb_t             win_q [3][3];
	logic [c3rgb_pkg::PIX_W-1:0] alpha_d_q;

	// stages 2..4
	logic                     v_s2, v_s3, v_s4;
	c3rgb_pkg::meta_t         meta_s2, meta_s3, meta_s4;
	logic signed [c3rgb_pkg::PROD_W-1:0] prod_s3 [3][3][3];
	logic signed [c3rgb_pkg::RSUM_W-1:0] rsum_s4 [3][3];
	logic signed [c3rgb_pkg::TSUM_W-1:0] tsum [3];
	logic [c3rgb_pkg::PIX_W-1:0]         chan [3];

	// output register
	logic                         m_valid_q, m_last_q;
	logic [c3rgb_pkg::OUT_W-1:0]  m_data_q;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ktop_q   <= c3rgb_pkg::KERNEL_TOP_RESET;
			kmid_q   <= c3rgb_pkg::KERNEL_MIDDLE_RESET;
			kbot_q   <= c3rgb_pkg::KERNEL_BOTTOM_RESET;
			width_q  <= c3rgb_pkg::WIDTH_RESET;
			height_q <= c3rgb_pkg::HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[5:3])
				c3rgb_pkg::REG_KERNEL_TOP:    ktop_q   <= pwdata[c3rgb_pkg::KROW_W-1:0];
				c3rgb_pkg::REG_KERNEL_MIDDLE: kmid_q   <= pwdata[c3rgb_pkg::KROW_W-1:0];
				c3rgb_pkg::REG_KERNEL_BOTTOM: kbot_q   <= pwdata[c3rgb_pkg::KROW_W-1:0];
				c3rgb_pkg::REG_IMAGE_WIDTH:   width_q  <= pwdata[c3rgb_pkg::DIM_W-1:0];
				c3rgb_pkg::REG_IMAGE_HEIGHT:  height_q <= pwdata[c3rgb_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[5:3])
			c3rgb_pkg::REG_KERNEL_TOP:    prdata = c3rgb_pkg::CFG_W'(ktop_q);
			c3rgb_pkg::REG_KERNEL_MIDDLE: prdata = c3rgb_pkg::CFG_W'(kmid_q);
			c3rgb_pkg::REG_KERNEL_BOTTOM: prdata = c3rgb_pkg::CFG_W'(kbot_q);
			c3rgb_pkg::REG_IMAGE_WIDTH:   prdata = c3rgb_pkg::CFG_W'(width_q);
			c3rgb_pkg::REG_IMAGE_HEIGHT:  prdata = c3rgb_pkg::CFG_W'(height_q);
			default:                      prdata = '0;
		endcase
	end

	assign krow[0] = ktop_q;
	assign krow[1] = kmid_q;
	assign krow[2] = kbot_q;

	// ---------------- position of the incoming pixel ----------------
	always_comb begin
		if (width_q == '0) begin
			w_eff = CMPW'(1);
		end else if (CMPW'(width_q) > CMPW'(MAX_WIDTH)) begin
			w_eff = CMPW'(MAX_WIDTH);
		end else begin
			w_eff = CMPW'(width_q);
		end
		h_eff = (height_q == '0) ? c3rgb_pkg::ROW_W'(1) : height_q;

		// counters may lie beyond a size written since the last pixel
		wrap0   = CMPW'(col_q) >= w_eff;
		rtmp0   = wrap0 ? row_q + 1'b1 : row_q;
		r0      = (rtmp0 >= h_eff) ? '0 : rtmp0;
		c0      = wrap0 ? '0 : col_q;
		c0_next = CMPW'(c0) + CMPW'(1);
		r0_inc  = r0 + 1'b1;
		emit0   = (r0 >= c3rgb_pkg::ROW_W'(2)) && (c0 >= AW'(2));
		last0   = (r0 == h_eff - 1'b1) && (CMPW'(c0) == w_eff - CMPW'(1));
	end

	assign adv    = !m_valid_q || m_axis_tready;
	assign accept = s_axis_tvalid && adv;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (c0_next >= w_eff) begin
				col_q <= '0;
				row_q <= (r0_inc >= h_eff) ? '0 : r0_inc;
			end else begin
				col_q <= AW'(c0_next);
				row_q <= r0;
			end
		end
	end

	// ---------------- line stores ----------------
	// read on accept; the write of the item in stage 1 lands on the same edge,
	// so a read of that same column (one-pixel rows) is bypassed
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_ram_s1 <= prev_mem[c0];
			old_ram_s1  <= old_mem[c0];
		end
		if (adv && v_s1) begin
			prev_mem[c_s1] <= {alpha_s1, rgb_s1};
			old_mem[c_s1]  <= prev_val[c3rgb_pkg::RGB_W-1:0];
		end
	end

	assign prev_val = fwd_s1 ? fwd_prev_s1 : prev_ram_s1;
	assign old_val  = fwd_s1 ? fwd_old_s1  : old_ram_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_s1      <= v_s1 && (c_s1 == c0);
			fwd_prev_s1 <= {alpha_s1, rgb_s1};
			fwd_old_s1  <= prev_val[c3rgb_pkg::RGB_W-1:0];
			c_s1        <= c0;
			col_s1      <= c3rgb_pkg::COL_W'(c0 - AW'(1));
			row_s1      <= r0 - 1'b1;
			emit_s1     <= emit0;
			last_s1     <= last0;
			rgb_s1      <= s_axis_tdata[c3rgb_pkg::RGB_W-1:0];
			alpha_s1    <= s_axis_tdata[c3rgb_pkg::RGBA_W-1:c3rgb_pkg::RGB_W];
		end
	end

	// ---------------- window and pipeline valids ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[k][j] <= '0;
				end
			end
			alpha_d_q <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			m_valid_q <= 1'b0;
		end else if (adv) begin
			if (v_s1) begin
				for (int k = 0; k < 3; k++) begin
					win_q[k][0] <= win_q[k][1];
					win_q[k][1] <= win_q[k][2];
				end
				win_q[0][2] <= old_val;
				win_q[1][2] <= prev_val[c3rgb_pkg::RGB_W-1:0];
				win_q[2][2] <= rgb_s1;
				alpha_d_q   <= prev_val[c3rgb_pkg::RGBA_W-1:c3rgb_pkg::RGB_W];
			end
			v_s1      <= s_axis_tvalid;
			v_s2      <= v_s1 && emit_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			m_valid_q <= v_s4;
		end
	end

	// ---------------- arithmetic pipeline ----------------
	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2.last  <= last_s1;
			meta_s2.col   <= col_s1;
			meta_s2.row   <= row_s1;
			meta_s2.alpha <= alpha_d_q;  // centre alpha once the window has shifted
			meta_s3       <= meta_s2;
			meta_s4       <= meta_s3;
			for (int ch = 0; ch < 3; ch++) begin
				for (int ky = 0; ky < 3; ky++) begin
					for (int kx = 0; kx < 3; kx++) begin
						prod_s3[ch][ky][kx] <= c3rgb_pkg::mul_coef(
							krow[ky][c3rgb_pkg::COEF_W*kx +: c3rgb_pkg::COEF_W],
							win_q[ky][kx][c3rgb_pkg::PIX_W*ch +: c3rgb_pkg::PIX_W]);
					end
					rsum_s4[ch][ky] <= c3rgb_pkg::RSUM_W'(prod_s3[ch][ky][0])
						+ c3rgb_pkg::RSUM_W'(prod_s3[ch][ky][1])
						+ c3rgb_pkg::RSUM_W'(prod_s3[ch][ky][2]);
				end
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			tsum[ch] = c3rgb_pkg::TSUM_W'(rsum_s4[ch][0])
				+ c3rgb_pkg::TSUM_W'(rsum_s4[ch][1])
				+ c3rgb_pkg::TSUM_W'(rsum_s4[ch][2]);
			chan[ch] = c3rgb_pkg::round_clamp(tsum[ch]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_data_q <= {1'b0, meta_s4.alpha, chan[2], chan[1], chan[0],
				meta_s4.row, meta_s4.col};
			m_last_q <= meta_s4.last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

	// ---------------- assertions ----------------
	`C3_ASSERT_IMPLY(a_row_nonzero, clk, arst_n, m_valid_q, m_data_q[22:11] != '0)
	`C3_ASSERT_IMPLY(a_last_pos, clk, arst_n, m_valid_q && m_last_q, (m_data_q[22:11] == h_eff - c3rgb_pkg::ROW_W'(2)) && (m_data_q[10:0] == c3rgb_pkg::COL_W'(w_eff - CMPW'(2))))
	`C3_ASSERT_IMPLY(a_s1_col_range, clk, arst_n, v_s1, CMPW'(c_s1) < w_eff)
	`C3_ASSERT_NEXT(a_s4_to_out, clk, arst_n, adv && v_s4, m_valid_q)
	`C3_ASSERT_IMPLY(a_out_from_pipe, clk, arst_n, $rose(m_valid_q), $past(v_s4))

endmodule

>>> test/tb_conv3x3_rgb_filter_top.sv
// Self-checking testbench for the 3x3 RGB convolution filter: directed, resize and random frames.
package tb_conv3x3_check_pkg;
	import c3rgb_pkg::*;

	typedef struct packed {
		bit [COL_W-1:0] col;
		bit [ROW_W-1:0] row;
		bit [PIX_W-1:0] red;
		bit [PIX_W-1:0] green;
		bit [PIX_W-1:0] blue;
		bit [PIX_W-1:0] alpha;
		bit             done;
	} filtered_pixel_t;

	class filter_scoreboard;
		bit [KROW_W-1:0] kernel [3];
		bit [DIM_W-1:0]  width_reg;
		bit [DIM_W-1:0]  height_reg;
		bit [RGBA_W-1:0] line_above [MAX_WIDTH_DEF];
		bit [RGB_W-1:0]  line_two_up [MAX_WIDTH_DEF];
		bit [RGB_W-1:0]  window [3][3];
		bit [PIX_W-1:0]  centre_alpha [3];
		int unsigned     col_pos;
		int unsigned     row_pos;
		filtered_pixel_t expected_pixels [$];
		int              mismatches;

		function new();
			kernel[0]  = KERNEL_TOP_RESET;
			kernel[1]  = KERNEL_MIDDLE_RESET;
			kernel[2]  = KERNEL_BOTTOM_RESET;
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			col_pos    = 0;
			row_pos    = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [CFG_W-1:0] value);
			case (idx)
				REG_KERNEL_TOP: begin
					kernel[0] = value[KROW_W-1:0];
				end
				REG_KERNEL_MIDDLE: begin
					kernel[1] = value[KROW_W-1:0];
				end
				REG_KERNEL_BOTTOM: begin
					kernel[2] = value[KROW_W-1:0];
				end
				REG_IMAGE_WIDTH: begin
					width_reg = value[DIM_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					height_reg = value[DIM_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		// weighted sum of one channel, half added, floored and clamped
		function bit [PIX_W-1:0] filter_channel(int unsigned sh);
			longint acc;
			bit signed [COEF_W-1:0] coef;
			acc = 0;
			for (int ky = 0; ky < 3; ky++) begin
				for (int kx = 0; kx < 3; kx++) begin
					coef = kernel[ky][16*kx +: 16];
					acc += coef * longint'(window[ky][kx][sh +: 8]);
				end
			end
			acc += longint'(1) << (COEF_FRAC_BITS - 1);
			if (acc < 0) begin
				return '0;
			end
			acc = acc >>> COEF_FRAC_BITS;
			return (acc > 255) ? 8'd255 : acc[7:0];
		endfunction

		function void note_pixel(logic [RGBA_W-1:0] px);
			int unsigned w, h, c, r;
			bit [RGBA_W-1:0] above;
			bit [RGB_W-1:0]  two_up;
			filtered_pixel_t res;
			w = 32'(width_reg);
			if (w < 1) w = 1;
			if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
			h = 32'(height_reg);
			if (h < 1) h = 1;
			// position left over from a larger size wraps to the next row or frame
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos = (row_pos + 1) & 'hFFF;
			end
			if (row_pos >= h) row_pos = 0;
			c = col_pos;
			r = row_pos;
			above  = line_above[c];
			two_up = line_two_up[c];
			for (int k = 0; k < 3; k++) begin
				window[k][0] = window[k][1];
				window[k][1] = window[k][2];
			end
			window[0][2] = two_up;
			window[1][2] = above[RGB_W-1:0];
			window[2][2] = px[RGB_W-1:0];
			centre_alpha[0] = centre_alpha[1];
			centre_alpha[1] = centre_alpha[2];
			centre_alpha[2] = above[31:24];
			line_two_up[c] = above[RGB_W-1:0];
			line_above[c]  = px;
			if (r >= 2 && c >= 2) begin
				res.col   = COL_W'(c - 1);
				res.row   = ROW_W'(r - 1);
				res.red   = filter_channel(0);
				res.green = filter_channel(8);
				res.blue  = filter_channel(16);
				res.alpha = centre_alpha[1];
				res.done  = (r == h - 1) && (c == w - 1);
				expected_pixels.push_back(res);
			end
			col_pos = (c + 1) & 'hFFF;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos = r + 1;
				if (row_pos >= h) row_pos = 0;
			end
		endfunction

		task report(string msg);
			mismatches++;
			$display("mismatch: %s", msg);
		endtask

		task check_field(string name, logic [11:0] got, logic [11:0] want, filtered_pixel_t px);
			if (got !== want) begin
				report($sformatf("%s at col %0d row %0d: got %0h, want %0h",
					name, px.col, px.row, got, want));
			end
		endtask

		task check_result(logic [OUT_W-1:0] d, logic last);
			filtered_pixel_t want;
			if (expected_pixels.size() == 0) begin
				report($sformatf("result with nothing pending: data %h", d));
				return;
			end
			want = expected_pixels.pop_front();
			check_field("out_col", 12'(d[10:0]), 12'(want.col), want);
			check_field("out_row", d[22:11], want.row, want);
			check_field("red_out", 12'(d[30:23]), 12'(want.red), want);
			check_field("green_out", 12'(d[38:31]), 12'(want.green), want);
			check_field("blue_out", 12'(d[46:39]), 12'(want.blue), want);
			check_field("alpha_out", 12'(d[54:47]), 12'(want.alpha), want);
			check_field("frame_done", 12'(last), 12'(want.done), want);
		endtask
	endclass
endpackage

module tb_conv3x3_rgb_filter_top;
	timeunit 1ns;
	timeprecision 1ps;
	import c3rgb_pkg::*;
	import tb_conv3x3_check_pkg::*;

	localparam int IDLE_LIMIT    = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PIXELS = 370;
	// widest image in the random frames, and the width of the priming frame
	localparam int PRIME_WIDTH   = 40;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [CFG_W-1:0]   pwdata;
	logic [CFG_W-1:0]   prdata;
	logic               pready;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	// red_in[7:0], green_in[15:8], blue_in[23:16], alpha_in[31:24]
	logic [RGBA_W-1:0]  s_axis_tdata;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	// out_col[10:0], out_row[22:11], red_out[30:23], green_out[38:31],
	// blue_out[46:39], alpha_out[54:47], zero[55]
	logic [OUT_W-1:0]   m_axis_tdata;
	logic               m_axis_tlast;

	filter_scoreboard board;
	bit               src_idling;
	bit               sink_idling;
	bit               hold_request;
	int               idle_cycles;

	conv3x3_rgb_filter_top dut (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// transfers are noted and checked here; the watchdog counts quiet cycles
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) board.note_pixel(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tlast);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(psel && penable && pwrite && pready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_axis_tready <= !(sink_idling && $urandom_range(99) < 8);
		end
	end

	task automatic apb_write(input logic [2:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.write_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_size(input int w, input int h);
		apb_write(REG_IMAGE_WIDTH, CFG_W'(w));
		apb_write(REG_IMAGE_HEIGHT, CFG_W'(h));
	endtask

	task automatic load_kernel(input logic [KROW_W-1:0] top, input logic [KROW_W-1:0] mid,
		input logic [KROW_W-1:0] bot);
		apb_write(REG_KERNEL_TOP, CFG_W'(top));
		apb_write(REG_KERNEL_MIDDLE, CFG_W'(mid));
		apb_write(REG_KERNEL_BOTTOM, CFG_W'(bot));
	endtask

	function automatic logic [KROW_W-1:0] random_kernel_row();
		logic [COEF_W-1:0] k [3];
		int unsigned mode;
		mode = $urandom_range(9);
		foreach (k[i]) begin
			if (mode < 3) begin
				k[i] = COEF_W'($urandom_range(0, 56));
			end else if (mode < 6) begin
				k[i] = COEF_W'(int'($urandom_range(0, 768)) - 384);
			end else if (mode < 8) begin
				k[i] = COEF_W'($urandom());
			end else begin
				case ($urandom_range(4))
					0: k[i] = 16'h7FFF;
					1: k[i] = 16'h8000;
					2: k[i] = 16'h0000;
					3: k[i] = 16'h0100;
					default: k[i] = 16'hFF00;
				endcase
			end
		end
		return {k[2], k[1], k[0]};
	endfunction

	function automatic logic [RGBA_W-1:0] next_pixel();
		logic [RGBA_W-1:0] px;
		px = $urandom();
		if ($urandom_range(9) == 0) px = $urandom_range(1) ? {RGBA_W{1'b1}} : '0;
		return px;
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_pixel(input logic [RGBA_W-1:0] px);
		if (src_idling && $urandom_range(99) < 8) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic send_pixels(input int n);
		repeat (n) send_pixel(next_pixel());
		s_axis_tvalid <= 1'b0;
	endtask

	// idle point: nothing pending, then enough cycles for the pipeline to empty
	task automatic drain();
		while (board.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [RGBA_W-1:0] corner_mix [9];
		int sent_random;
		int w, h, n;
		board         = new();
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		src_idling    = 1'b1;
		sink_idling   = 1'b1;
		hold_request  = 1'b0;
		idle_cycles   = 0;
		corner_mix = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFF00_FF00, 32'h00FF_00FF,
			32'h8040_2010, 32'h7F7F_7F7F, 32'h8080_8080, 32'hFFFF_FFFF, 32'h0000_0000};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// 3x3 frames: reset kernel, then all coefficients at the negative and positive limits
		set_size(3, 3);
		for (int f = 0; f < 3; f++) begin
			if (f == 1) load_kernel({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
			if (f == 2) load_kernel({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
			foreach (corner_mix[i]) send_pixel(corner_mix[i]);
			s_axis_tvalid <= 1'b0;
			drain();
		end

		// frame with no idling at the widest random size; it fills every
		// line store entry that the later frames read
		src_idling  = 1'b0;
		sink_idling = 1'b0;
		load_kernel(random_kernel_row(), random_kernel_row(), random_kernel_row());
		set_size(PRIME_WIDTH, 3);
		send_pixels(PRIME_WIDTH * 3);
		drain();
		src_idling  = 1'b1;
		sink_idling = 1'b1;

		// width register beyond the line length acts as the full line; first pixels only
		load_kernel(random_kernel_row(), random_kernel_row(), random_kernel_row());
		set_size(4095, 3);
		send_pixels(6);
		drain();

		// tallest image on the narrowest interior, first rows only
		set_size(3, 4095);
		send_pixels(3 * 6);
		drain();

		// sizes too small for any interior pixel, zero acting as one
		set_size(0, 0);
		send_pixels(5);
		drain();
		set_size(1, 5);
		send_pixels(6);
		drain();
		set_size(2, 4095);
		send_pixels(10);
		drain();
		set_size(9, 2);
		send_pixels(20);
		drain();
		set_size(5, 1);
		send_pixels(7);
		drain();

		// shrink mid-frame: column past the new width, then row past the new height
		set_size(8, 6);
		send_pixels(21);
		drain();
		apb_write(REG_IMAGE_WIDTH, CFG_W'(4));
		send_pixels(12);
		drain();
		set_size(5, 5);
		send_pixels(17);
		drain();
		apb_write(REG_IMAGE_HEIGHT, CFG_W'(3));
		send_pixels(15);
		drain();

		sent_random = 0;
		for (int phase = 0; sent_random < RANDOM_PIXELS; phase++) begin
			if ($urandom_range(2) == 0) apb_write(REG_KERNEL_TOP, CFG_W'(random_kernel_row()));
			if ($urandom_range(2) == 0) apb_write(REG_KERNEL_MIDDLE, CFG_W'(random_kernel_row()));
			if ($urandom_range(2) == 0) apb_write(REG_KERNEL_BOTTOM, CFG_W'(random_kernel_row()));
			case ($urandom_range(9))
				0: begin
					w = $urandom_range(0, 2);
					h = $urandom_range(0, 6);
				end
				1: begin
					w = $urandom_range(13, PRIME_WIDTH);
					h = $urandom_range(3, 5);
				end
				2: begin
					w = $urandom_range(3, 6);
					h = $urandom_range(0, 2);
				end
				default: begin
					w = $urandom_range(3, 12);
					h = $urandom_range(3, 6);
				end
			endcase
			if (phase == 0) begin
				w = 10;
				h = 8;
			end
			set_size(w, h);
			if (w == 0) w = 1;
			if (h == 0) h = 1;
			// mostly whole frames, now and then a frame cut short
			if (phase != 0 && $urandom_range(4) == 0) begin
				n = $urandom_range(1, w * h);
			end else begin
				n = w * h * $urandom_range(1, 2);
			end
			if (n > RANDOM_PIXELS - sent_random) n = RANDOM_PIXELS - sent_random;
			// receiver holds off while the sender keeps offering transfers
			if (phase == 0) hold_request = 1'b1;
			send_pixels(n);
			sent_random += n;
			drain();
		end

		if (board.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
